// ===== src/skl_pkg.sv =====
// Shared types and constants for the sorted key list.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package skl_pkg;

   localparam int unsigned KEY_WIDTH        = 32;
   localparam int unsigned COMMAND_WIDTH    = 2;
   localparam int unsigned STATUS_WIDTH     = 2;
   localparam int unsigned ENTRY_WIDTH      = 7;
   localparam int unsigned DEFAULT_CAPACITY = 64;

   typedef enum logic [COMMAND_WIDTH-1:0] {
      CMD_SEARCH = 2'd0,
      CMD_INSERT = 2'd1,
      CMD_REMOVE = 2'd2
   } command_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic compare;
      logic apply;
   } ctrl_type;

endpackage : skl_pkg

`default_nettype wire

// ===== src/sorted_key_list.sv =====
// Sorted key list: up to CAPACITY signed keys held in ascending order.
// Each request word carries a command (search, insert, remove) and a key;
// each request yields exactly one response word with a status and the
// number of keys held after the operation.
// Both channels use valid and stall; a word moves when valid is high and
// stall is low. One request is worked on at a time. A request passes through
// a compare step, in which every cell of the chain compares its key against
// the request key, and an apply step, in which the chain shifts to open or
// close a gap and the response register is loaded. The response is visible
// the cycle after that, and the next request is taken in the same cycle in
// which the previous result is written.
// When the receiver stalls, the response holds; the block finishes the
// compare of a request already taken and then stalls the requester until
// the response register is free.
// Reset empties the list and drops any response in flight; no clearing
// pass is needed.
// Depends on skl_pkg, skl_ctrl and skl_datapath.
`default_nettype none

module sorted_key_list #(
   parameter int unsigned CAPACITY = skl_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [skl_pkg::COMMAND_WIDTH-1:0]     req_command,
   input  wire logic signed [skl_pkg::KEY_WIDTH-1:0]  req_key,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic      [skl_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic      [skl_pkg::ENTRY_WIDTH-1:0]       rsp_entry_count
);
   import skl_pkg::*;

   ctrl_type ctrl;

   skl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   skl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .req_command     (req_command),
      .req_key         (req_key),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule : sorted_key_list

`default_nettype wire

// ===== src/skl_datapath.sv =====
// Cell chain, per-cell comparators, count and response registers.
// Depends on skl_pkg; steered by skl_ctrl through a ctrl_type command.
`default_nettype none

module skl_datapath #(
   parameter int unsigned CAPACITY = skl_pkg::DEFAULT_CAPACITY
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire skl_pkg::ctrl_type                     ctrl,
   input  wire logic [skl_pkg::COMMAND_WIDTH-1:0]     req_command,
   input  wire logic signed [skl_pkg::KEY_WIDTH-1:0]  req_key,
   output logic      [skl_pkg::STATUS_WIDTH-1:0]      rsp_status,
   output logic      [skl_pkg::ENTRY_WIDTH-1:0]       rsp_entry_count
);
   import skl_pkg::*;

   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

   logic signed [KEY_WIDTH-1:0]     cell_ff [CAPACITY];
   logic signed [KEY_WIDTH-1:0]     key_ff;
   logic        [COMMAND_WIDTH-1:0] command_ff;
   logic        [CW-1:0]            count_ff;
   logic        [CW-1:0]            count_in;
   logic        [CAPACITY-1:0]      below_ff;
   logic        [CAPACITY-1:0]      below_in;
   logic        [CAPACITY-1:0]      equal_ff;
   logic        [CAPACITY-1:0]      equal_in;
   logic        [STATUS_WIDTH-1:0]  status_ff;
   logic        [STATUS_WIDTH-1:0]  status_in;
   logic        [ENTRY_WIDTH-1:0]   entry_count_ff;
   logic        [CW+ENTRY_WIDTH-1:0] count_wide;
   logic                            found;
   logic                            full;
   logic                            insert_en;
   logic                            remove_en;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_ff     <= req_key;
         command_ff <= req_command;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      localparam logic [CW-1:0] IDX = CW'(i);
      logic signed [KEY_WIDTH-1:0] cell_in;

      assign below_in[i] = (IDX < count_ff) && (cell_ff[i] < key_ff);
      assign equal_in[i] = (IDX < count_ff) && (cell_ff[i] == key_ff);

      always_comb begin
         cell_in = cell_ff[i];
         if (insert_en && !below_ff[i]) begin
            if (i == 0) begin
               cell_in = key_ff;
            end else begin
               cell_in = below_ff[(i == 0) ? 0 : i - 1] ? key_ff
                                                         : cell_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (remove_en && !below_ff[i]) begin
            if (i < CAPACITY - 1) begin
               cell_in = cell_ff[(i < CAPACITY - 1) ? i + 1 : i];
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         below_ff <= below_in;
         equal_ff <= equal_in;
      end
   end

   assign found     = |equal_ff;
   assign full      = (count_ff == FULL_COUNT);
   assign insert_en = ctrl.apply && (command_ff == CMD_INSERT) && !full;
   assign remove_en = ctrl.apply && (command_ff == CMD_REMOVE) && found;

   always_comb begin
      count_in  = count_ff;
      status_in = STATUS_ABSENT;
      case (command_ff)
         CMD_SEARCH: begin
            status_in = found ? STATUS_OK : STATUS_ABSENT;
         end
         CMD_INSERT: begin
            status_in = full ? STATUS_FULL : STATUS_OK;
            if (!full) begin
               count_in = count_ff + CW'(1);
            end
         end
         CMD_REMOVE: begin
            status_in = found ? STATUS_OK : STATUS_ABSENT;
            if (found) begin
               count_in = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = STATUS_ABSENT;
         end
      endcase
   end

   assign count_wide = {{ENTRY_WIDTH{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.apply) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.apply) begin
         status_ff      <= status_in;
         entry_count_ff <= count_wide[ENTRY_WIDTH-1:0];
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_entry_count = entry_count_ff;

endmodule : skl_datapath

`default_nettype wire

// ===== src/skl_ctrl.sv =====
// Controller state machine for the sorted key list: handshakes and sequencing.
// Depends on skl_pkg; drives the datapath through a ctrl_type command.
`default_nettype none

module skl_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output skl_pkg::ctrl_type      ctrl
);
   import skl_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_APPLY) && out_free));

   always_comb begin
      ctrl         = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ctrl.load    = req_valid && !req_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            ctrl.compare = 1'b1;
            state_in     = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               ctrl.apply   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = req_valid ? ST_COMPARE : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule : skl_ctrl

`default_nettype wire

// ===== src/skl_checker.sv =====
// Port-level checks for the sorted key list, bound to the top level.
// Depends on skl_pkg and sorted_key_list.
`default_nettype none

module skl_checker #(
   parameter int unsigned CAPACITY = skl_pkg::DEFAULT_CAPACITY
) (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_valid,
   input wire logic                                  req_stall,
   input wire logic                                  rsp_valid,
   input wire logic                                  rsp_stall,
   input wire logic [skl_pkg::STATUS_WIDTH-1:0]      rsp_status,
   input wire logic [skl_pkg::ENTRY_WIDTH-1:0]       rsp_entry_count
);
   import skl_pkg::*;

   localparam logic [ENTRY_WIDTH-1:0] FULL_ENTRIES = ENTRY_WIDTH'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_entry_count))
      else $error("stalled response word changed");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request word taken while another is being compared");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_entry_count == FULL_ENTRIES)
      else $error("full status with a count below capacity");

endmodule : skl_checker

bind sorted_key_list skl_checker #(
   .CAPACITY (CAPACITY)
) u_skl_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_entry_count (rsp_entry_count)
);

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for sorted_key_list: directed and random search, insert,
// remove and unused-command words, checked against a behavioral mirror of the
// ordered key table. Depends on skl_pkg and the sorted_key_list RTL.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import skl_pkg::*;

   localparam int unsigned LIST_CAPACITY = DEFAULT_CAPACITY;
   localparam logic [COMMAND_WIDTH-1:0] CMD_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 400;
   localparam int PHASE_WORDS = 100;
   localparam int LONG_HOLD_AT = 150;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT = 200000;
   localparam int MAX_GAP = 17;

   typedef logic signed [KEY_WIDTH-1:0] key_type;

   typedef struct {
      status_type              status;
      logic [ENTRY_WIDTH-1:0] entry_count;
   } reply_type;

   class sorted_list_mirror;
      key_type   held_keys[$];
      reply_type pending_replies[$];
      int        mismatches = 0;

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatches++;
      endtask

      function void note_request(logic [COMMAND_WIDTH-1:0] command, key_type key);
         int        pos;
         bit        present;
         reply_type reply;
         pos = 0;
         while (pos < held_keys.size() && held_keys[pos] < key) pos++;
         present = (pos < held_keys.size()) && (held_keys[pos] == key);
         reply.status = STATUS_ABSENT;
         case (command)
            CMD_SEARCH: begin
               if (present) reply.status = STATUS_OK;
            end
            CMD_INSERT: begin
               if (held_keys.size() >= LIST_CAPACITY) begin
                  reply.status = STATUS_FULL;
               end else begin
                  held_keys.insert(pos, key);
                  reply.status = STATUS_OK;
               end
            end
            CMD_REMOVE: begin
               if (present) begin
                  held_keys.delete(pos);
                  reply.status = STATUS_OK;
               end
            end
            default: begin
            end
         endcase
         reply.entry_count = ENTRY_WIDTH'(held_keys.size());
         pending_replies.push_back(reply);
      endfunction

      task check_reply(logic [STATUS_WIDTH-1:0] status, logic [ENTRY_WIDTH-1:0] entry_count);
         reply_type wanted;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected word, status %0d count %0d",
                                      status, entry_count));
            return;
         end
         wanted = pending_replies.pop_front();
         if (status !== wanted.status)
            report_mismatch($sformatf("status %0d, wanted %0d", status, wanted.status));
         if (entry_count !== wanted.entry_count)
            report_mismatch($sformatf("entry count %0d, wanted %0d",
                                      entry_count, wanted.entry_count));
      endtask

      function key_type draw_key(int held_share);
         int r;
         r = $urandom_range(0, 99);
         if (r < held_share && held_keys.size() > 0)
            return held_keys[$urandom_range(0, held_keys.size() - 1)];
         if (r < held_share + (100 - held_share) / 2)
            return key_type'(int'($urandom_range(0, 16)) - 8);
         return key_type'($urandom);
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [COMMAND_WIDTH-1:0] req_command = CMD_SEARCH;
   key_type                  req_key = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic [ENTRY_WIDTH-1:0]   rsp_entry_count;

   sorted_list_mirror mirror = new();
   int words_sent = 0;
   int replies_taken = 0;
   int cycle_count = 0;

   sorted_key_list #(.CAPACITY(LIST_CAPACITY)) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_command    (req_command),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

   task automatic send_word(input logic [COMMAND_WIDTH-1:0] command, input key_type key);
      int gap;
      gap = ((words_sent / 40) % 3 != 2) ? $urandom_range(0, MAX_GAP) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_command <= COMMAND_WIDTH'($urandom);
         req_key <= key_type'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= command;
      req_key <= key;
      do @(posedge clock); while (req_stall);
      mirror.note_request(command, key);
      words_sent++;
      @(negedge clock);
   endtask

   initial begin : reply_side
      int gap;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (replies_taken == LONG_HOLD_AT)
            gap = LONG_HOLD_CYCLES;
         else
            gap = ((replies_taken / 40) % 3 != 1) ? $urandom_range(0, MAX_GAP) : 0;
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         mirror.check_reply(rsp_status, rsp_entry_count);
         replies_taken++;
         @(negedge clock);
      end
   end

   initial begin : request_side
      int                       r;
      int                       phase;
      logic [COMMAND_WIDTH-1:0] command;
      key_type                  key;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_word(CMD_SEARCH, 32'sh8000_0000);
      send_word(CMD_REMOVE, 32'sh0000_0005);
      send_word(CMD_UNUSED, 32'sh7FFF_FFFF);
      send_word(CMD_INSERT, 32'sh7FFF_FFFF);
      send_word(CMD_INSERT, 32'sh8000_0000);
      send_word(CMD_INSERT, 32'sh0000_0000);
      send_word(CMD_INSERT, 32'shFFFF_FFFF);
      send_word(CMD_INSERT, 32'sh0000_0001);
      send_word(CMD_INSERT, 32'sh0000_0000);
      send_word(CMD_SEARCH, 32'sh8000_0000);
      send_word(CMD_SEARCH, 32'sh7FFF_FFFF);
      send_word(CMD_SEARCH, 32'sh0000_0005);
      send_word(CMD_REMOVE, 32'sh0000_0000);
      send_word(CMD_SEARCH, 32'sh0000_0000);
      send_word(CMD_REMOVE, 32'sh0000_0000);
      send_word(CMD_SEARCH, 32'sh0000_0000);
      send_word(CMD_REMOVE, 32'sh0000_0007);
      send_word(CMD_UNUSED, 32'shFFFF_FFFF);
      send_word(CMD_REMOVE, 32'sh7FFF_FFFF);
      send_word(CMD_REMOVE, 32'sh8000_0000);
      send_word(CMD_SEARCH, 32'sh5A5A_A5A5);

      // Fill past capacity, drain, refill, then a mixed stretch.
      for (int index = 0; index < RANDOM_WORDS; index++) begin
         phase = (index / PHASE_WORDS) % 4;
         r = $urandom_range(0, 99);
         if (r >= 98) begin
            command = CMD_UNUSED;
         end else if (phase == 1) begin
            command = (r < 88) ? CMD_REMOVE : (r < 94) ? CMD_SEARCH : CMD_INSERT;
         end else if (phase == 3) begin
            command = (r < 35) ? CMD_INSERT : (r < 65) ? CMD_SEARCH : CMD_REMOVE;
         end else begin
            command = (r < 88) ? CMD_INSERT : (r < 94) ? CMD_SEARCH : CMD_REMOVE;
         end
         key = mirror.draw_key(command == CMD_INSERT ? 30 : 75);
         send_word(command, key);
      end
      req_valid <= 1'b0;

      while (mirror.pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mirror.mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
